/* rtl/sbpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpd_pkg
// Shared types, codes and helpers for the side-band pack demultiplexer.
// ----------------------------------------------------------------------------
package sbpd_pkg;

  localparam int LenWidth = 16;

  typedef enum logic [1:0] {
    KIND_PACK     = 2'd0,
    KIND_PROGRESS = 2'd1,
    KIND_REMOTE   = 2'd2,
    KIND_STATUS   = 2'd3
  } sbpd_kind_t;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_BAD_FRAME = 2'd1,
    STATUS_REMOTE    = 2'd2,
    STATUS_NO_PACK   = 2'd3
  } sbpd_status_t;

  typedef enum logic [1:0] {
    CLASS_NONE     = 2'd0,
    CLASS_PACK     = 2'd1,
    CLASS_PROGRESS = 2'd2,
    CLASS_REMOTE   = 2'd3
  } sbpd_class_t;

  localparam logic [2:0] PosDropped = 3'd7;
  localparam logic [2:0] PosMagicLen = 3'd4;

  localparam logic [7:0] PACK_MAGIC [4] = '{8'h50, 8'h41, 8'h43, 8'h4B};

  // Results caused by one accepted byte: an optional burst of the four magic
  // bytes, an optional data byte, and an optional closing status.
  typedef struct packed {
    logic         pack4;
    logic         has_data;
    sbpd_kind_t   data_kind;
    logic [7:0]   data_value;
    logic         has_status;
    sbpd_status_t status;
  } sbpd_event_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] digit;
  } sbpd_hex_t;

  function automatic sbpd_hex_t hex_decode(input logic [7:0] b);
    sbpd_hex_t r;
    r.ok    = 1'b1;
    r.digit = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.digit = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.digit = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.digit = 4'(b - 8'h57);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

/* rtl/sbpd_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpd_parser
// Frame parser: header decode, payload classification and status decisions.
// ----------------------------------------------------------------------------
module sbpd_parser
  import sbpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_response,
  input  logic        ev_ready,
  output logic        ev_valid,
  output sbpd_event_t ev
);

  logic [1:0]          header_count_r, header_count_nxt;
  logic [LenWidth-1:0] length_accum_r, length_accum_nxt;
  logic [LenWidth-1:0] bytes_left_r, bytes_left_nxt;
  logic [2:0]          payload_pos_r, payload_pos_nxt;
  sbpd_class_t         payload_class_r, payload_class_nxt;
  logic                pack_seen_r, pack_seen_nxt;
  logic                halted_r, halted_nxt;

  logic                in_xfer;
  sbpd_hex_t           hex;
  logic [LenWidth-1:0] frame_len;

  assign in_stall = !ev_ready;
  assign in_xfer  = in_valid && ev_ready;
  assign hex      = hex_decode(in_data_byte);
  assign frame_len = {length_accum_r[LenWidth-5:0], hex.digit};

  always_comb begin
    header_count_nxt  = header_count_r;
    length_accum_nxt  = length_accum_r;
    bytes_left_nxt    = bytes_left_r;
    payload_pos_nxt   = payload_pos_r;
    payload_class_nxt = payload_class_r;
    pack_seen_nxt     = pack_seen_r;
    halted_nxt        = halted_r;
    ev                = '0;
    ev.data_kind      = KIND_PACK;
    ev.status         = STATUS_DONE;

    if (halted_r) begin
      if (in_end_of_response) begin
        halted_nxt = 1'b0;
      end
    end else begin
      if (bytes_left_r != '0) begin
        unique case (payload_class_r)
          CLASS_NONE: begin
            if (payload_pos_r == 3'd0 && in_data_byte >= 8'd1 && in_data_byte <= 8'd3) begin
              payload_class_nxt = sbpd_class_t'(in_data_byte[1:0]);
              payload_pos_nxt   = 3'd1;
            end else if (payload_pos_r < PosMagicLen &&
                         in_data_byte == PACK_MAGIC[payload_pos_r[1:0]]) begin
              payload_pos_nxt = payload_pos_r + 3'd1;
              if (payload_pos_r == PosMagicLen - 3'd1) begin
                ev.pack4          = 1'b1;
                payload_class_nxt = CLASS_PACK;
                pack_seen_nxt     = 1'b1;
              end
            end else begin
              payload_pos_nxt = PosDropped;
            end
          end
          CLASS_PACK: begin
            ev.has_data   = 1'b1;
            ev.data_kind  = KIND_PACK;
            pack_seen_nxt = 1'b1;
          end
          CLASS_PROGRESS: begin
            ev.has_data  = 1'b1;
            ev.data_kind = KIND_PROGRESS;
          end
          CLASS_REMOTE: begin
            ev.has_data  = 1'b1;
            ev.data_kind = KIND_REMOTE;
          end
          default: begin
            ev.has_data = 1'b0;
          end
        endcase
        ev.data_value  = in_data_byte;
        bytes_left_nxt = bytes_left_r - LenWidth'(1);
        if (bytes_left_r == LenWidth'(1)) begin
          if (payload_class_nxt == CLASS_REMOTE) begin
            ev.has_status = 1'b1;
            ev.status     = STATUS_REMOTE;
          end
          payload_class_nxt = CLASS_NONE;
          payload_pos_nxt   = 3'd0;
        end
      end else begin
        if (!hex.ok) begin
          ev.has_status = 1'b1;
          ev.status     = STATUS_BAD_FRAME;
        end else if (header_count_r == 2'd3) begin
          header_count_nxt = 2'd0;
          length_accum_nxt = '0;
          if (frame_len >= LenWidth'(1) && frame_len <= LenWidth'(3)) begin
            ev.has_status = 1'b1;
            ev.status     = STATUS_BAD_FRAME;
          end else if (frame_len > LenWidth'(4)) begin
            bytes_left_nxt    = frame_len - LenWidth'(4);
            payload_pos_nxt   = 3'd0;
            payload_class_nxt = CLASS_NONE;
          end
        end else begin
          header_count_nxt = header_count_r + 2'd1;
          length_accum_nxt = frame_len;
        end
      end

      if (!ev.has_status && in_end_of_response) begin
        ev.has_status = 1'b1;
        if (header_count_nxt != 2'd0 || bytes_left_nxt != '0) begin
          ev.status = STATUS_BAD_FRAME;
        end else if (pack_seen_nxt) begin
          ev.status = STATUS_DONE;
        end else begin
          ev.status = STATUS_NO_PACK;
        end
      end

      if (ev.has_status) begin
        header_count_nxt  = 2'd0;
        length_accum_nxt  = '0;
        bytes_left_nxt    = '0;
        payload_pos_nxt   = 3'd0;
        payload_class_nxt = CLASS_NONE;
        pack_seen_nxt     = 1'b0;
        halted_nxt        = !in_end_of_response;
      end
    end

    if (halted_r && in_end_of_response) begin
      header_count_nxt  = 2'd0;
      length_accum_nxt  = '0;
      bytes_left_nxt    = '0;
      payload_pos_nxt   = 3'd0;
      payload_class_nxt = CLASS_NONE;
      pack_seen_nxt     = 1'b0;
    end
  end

  assign ev_valid = in_xfer && (ev.pack4 || ev.has_data || ev.has_status);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r  <= 2'd0;
      length_accum_r  <= '0;
      bytes_left_r    <= '0;
      payload_pos_r   <= 3'd0;
      payload_class_r <= CLASS_NONE;
      pack_seen_r     <= 1'b0;
      halted_r        <= 1'b0;
    end else if (in_xfer) begin
      header_count_r  <= header_count_nxt;
      length_accum_r  <= length_accum_nxt;
      bytes_left_r    <= bytes_left_nxt;
      payload_pos_r   <= payload_pos_nxt;
      payload_class_r <= payload_class_nxt;
      pack_seen_r     <= pack_seen_nxt;
      halted_r        <= halted_nxt;
    end
  end

`ifndef SYNTH
  a_halted_idle: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> (bytes_left_r == '0 && header_count_r == 2'd0 && !pack_seen_r))
    else $error("parser halted with frame state still live");

  a_class_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (payload_class_r != CLASS_NONE) |-> (bytes_left_r != '0))
    else $error("payload class set outside a payload");

  a_status_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_valid && ev.has_status && !in_end_of_response) |=> halted_r)
    else $error("error status did not halt the parser");
`endif

endmodule

/* rtl/sbpd_serializer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpd_serializer
// Result register that expands one parser event into its output transfers.
// ----------------------------------------------------------------------------
module sbpd_serializer
  import sbpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        ev_valid,
  input  sbpd_event_t ev,
  output logic        ev_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_value,
  output logic [1:0]  out_status,
  output logic        out_last
);

  logic        valid_r;
  sbpd_event_t cur_r;
  logic [1:0]  idx_r;

  logic out_xfer;
  logic pack_phase;
  logic data_phase;
  logic final_item;

  assign pack_phase = cur_r.pack4;
  assign data_phase = !cur_r.pack4 && cur_r.has_data;
  assign final_item = (pack_phase && idx_r == 2'd3 && !cur_r.has_status) ||
                      (data_phase && !cur_r.has_status) ||
                      (!pack_phase && !data_phase);

  assign out_valid = valid_r;
  assign out_xfer  = valid_r && !out_stall;
  assign ev_ready  = !valid_r || (out_xfer && final_item);

  always_comb begin
    if (pack_phase) begin
      out_kind   = KIND_PACK;
      out_value  = PACK_MAGIC[idx_r];
      out_status = STATUS_DONE;
      out_last   = 1'b0;
    end else if (data_phase) begin
      out_kind   = cur_r.data_kind;
      out_value  = cur_r.data_value;
      out_status = STATUS_DONE;
      out_last   = 1'b0;
    end else begin
      out_kind   = KIND_STATUS;
      out_value  = 8'd0;
      out_status = cur_r.status;
      out_last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (ev_ready) begin
      valid_r <= ev_valid;
      idx_r   <= 2'd0;
    end else if (out_xfer && pack_phase) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_ready) begin
      cur_r <= ev;
    end else if (out_xfer) begin
      if (pack_phase && idx_r == 2'd3) begin
        cur_r.pack4 <= 1'b0;
      end else if (data_phase) begin
        cur_r.has_data <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_kind == KIND_STATUS && out_value == 8'd0))
    else $error("last flag on a data transfer");

  a_push_only_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid |-> ev_ready)
    else $error("event pushed into a busy result register");

  a_drain_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && final_item && !ev_valid) |=> !out_valid)
    else $error("result register did not empty after its final transfer");
`endif

endmodule

/* rtl/sideband_pack_demux.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sideband_pack_demux
// Byte-serial pkt-line side-band demultiplexer for an upload-pack response.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  in_      input      in_valid/in_stall   data_byte[7:0], end_of_response
//  out_     output     out_valid/out_stall kind[1:0], value[7:0], status[1:0], last
//
// A byte is parsed in the cycle it is accepted and its first result is offered
// in the next cycle, so bytes with at most one transfer flow one per cycle while out_stall is low.
// A byte with more than one transfer stalls the input until its last transfer
// is taken: two transfers for a data byte that also closes the response, four or
// five for the byte that completes the "PACK" prefix.
// Reset is synchronous and needs no clearing pass.
// in_stall follows out_stall combinationally while the last transfer of a byte waits.
// ----------------------------------------------------------------------------
module sideband_pack_demux
  import sbpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_response,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_value,
  output logic [1:0] out_status,
  output logic       out_last
);

  logic        ev_valid;
  logic        ev_ready;
  sbpd_event_t ev;

  sbpd_parser u_parser (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_end_of_response (in_end_of_response),
    .ev_ready           (ev_ready),
    .ev_valid           (ev_valid),
    .ev                 (ev)
  );

  sbpd_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .ev_valid   (ev_valid),
    .ev         (ev),
    .ev_ready   (ev_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_value  (out_value),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule
